// ===== rtl/core/mvna_pkg.sv =====
package mvna_pkg;

	localparam int VERTEX_SLOTS = 4096;
	localparam int IDX_W = $clog2(VERTEX_SLOTS);
	localparam int SUM_W = 24;
	localparam int CNT_W = 8;
	localparam int Q15_MAX = 32767;

	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_TRI  = 2'd1,
		ACT_READ = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [11:0]        index_a;
		logic [11:0]        index_b;
		logic [11:0]        index_c;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic signed [15:0] coord_z;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic [7:0]         face_count;
		logic               status;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_RD_C,
		ST_RD_W,
		ST_CROSS1,
		ST_CROSS2,
		ST_CROSS3,
		ST_RSUM_W,
		ST_RSUM,
		ST_SHIFT,
		ST_SQ,
		ST_SQRT,
		ST_DIV,
		ST_ACC_RD,
		ST_ACC_W,
		ST_ACC_WR,
		ST_OUT
	} state_t;

endpackage

// ===== rtl/core/mvna_in_if.sv =====
interface mvna_in_if;
	logic valid;
	logic ready;
	mvna_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mvna_out_if.sv =====
interface mvna_out_if;
	logic valid;
	logic ready;
	mvna_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mesh_vertex_normal_accumulator.sv =====
// One transaction at a time: load, triangle, read and unused actions each run to a
// result, and the next can be taken the cycle after the result is taken.
// Normalization uses the 32-step square root and the three 16-step restoring
// divisions of one normalization unit.
// Reset: arst_n clears control state only; vertex and sum memories are not
// cleared and hold unknown data until a load writes an entry.
module mesh_vertex_normal_accumulator (
	input logic clk,
	input logic arst_n,
	mvna_in_if.sink in_ch,
	mvna_out_if.source out_ch
);

	localparam int IW = mvna_pkg::IDX_W;
	localparam int SW = mvna_pkg::SUM_W;

	mvna_pkg::state_t state_q, state_d;

	logic [47:0] coord_mem [mvna_pkg::VERTEX_SLOTS];
	logic [3*SW+7:0] acc_mem [mvna_pkg::VERTEX_SLOTS];

	logic [47:0] coord_rd_q;
	logic [3*SW+7:0] acc_rd_q;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	logic coord_we, acc_we;
	logic [47:0] coord_wd;
	logic [3*SW+7:0] acc_wd;

	mvna_pkg::in_item_t item_q;
	logic signed [16:0] va_q [3];
	logic signed [16:0] e1_q [3];
	logic signed [16:0] e2_q [3];
	logic signed [34:0] prod_q;
	logic signed [40:0] c_q [3];
	logic [40:0] a_q [3];
	logic neg_q [3];
	logic [1:0] step_q;
	logic [5:0] cnt_q;
	logic [63:0] sq_q;
	logic [63:0] rem_q;
	logic [31:0] root_q;
	logic [15:0] dnum_q;
	logic [15:0] quo_q;
	logic [32:0] drem_q;
	logic signed [15:0] n_q [3];
	logic status_q;
	logic [7:0] count_q;
	logic [1:0] corner_q;
	mvna_pkg::out_item_t out_q;
	logic out_valid_q;

	logic [IW-1:0] idx_a, idx_b, idx_c, corner_idx;
	assign idx_a = item_q.index_a[IW-1:0];
	assign idx_b = item_q.index_b[IW-1:0];
	assign idx_c = item_q.index_c[IW-1:0];

	always_comb begin
		case (corner_q)
			2'd0: corner_idx = idx_a;
			2'd1: corner_idx = idx_b;
			default: corner_idx = idx_c;
		endcase
	end

	always_ff @(posedge clk) begin
		if (coord_we) coord_mem[wr_addr] <= coord_wd;
		coord_rd_q <= coord_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (acc_we) acc_mem[wr_addr] <= acc_wd;
		acc_rd_q <= acc_mem[rd_addr];
	end

	assign in_ch.ready = (state_q == mvna_pkg::ST_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	logic in_fire;
	assign in_fire = in_ch.valid && in_ch.ready;

	// coordinate unpack
	logic signed [16:0] rd_co [3];
	assign rd_co[0] = {coord_rd_q[47], coord_rd_q[47:32]};
	assign rd_co[1] = {coord_rd_q[31], coord_rd_q[31:16]};
	assign rd_co[2] = {coord_rd_q[15], coord_rd_q[15:0]};

	// saturating accumulate
	function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s, input logic signed [15:0] d);
		logic signed [SW:0] r;
		begin
			r = $signed({s[SW-1], s}) + (SW+1)'(d);
			if (r > $signed((SW+1)'(8388607))) sat_add = SW'(8388607);
			else if (r < $signed(-(SW+1)'(8388608))) sat_add = SW'(-8388608);
			else sat_add = r[SW-1:0];
		end
	endfunction

	logic [7:0] acc_cnt;
	assign acc_cnt = acc_rd_q[7:0];

	// max magnitude for shift
	logic [40:0] a_max;
	always_comb begin
		a_max = a_q[0];
		if (a_q[1] > a_max) a_max = a_q[1];
		if (a_q[2] > a_max) a_max = a_q[2];
	end

	// cross product terms
	logic signed [34:0] prod_a, prod_b;
	always_comb begin
		case (step_q)
			2'd0: begin
				prod_a = e1_q[1] * e2_q[2];
				prod_b = e1_q[2] * e2_q[1];
			end
			2'd1: begin
				prod_a = e1_q[2] * e2_q[0];
				prod_b = e1_q[0] * e2_q[2];
			end
			default: begin
				prod_a = e1_q[0] * e2_q[1];
				prod_b = e1_q[1] * e2_q[0];
			end
		endcase
	end

	// sqrt step
	logic [63:0] sqrt_trial;
	logic [63:0] sqrt_rem_sh;
	assign sqrt_rem_sh = {rem_q[61:0], sq_q[63:62]};
	assign sqrt_trial = {30'd0, root_q, 2'b01};

	// divide step
	logic [32:0] div_sh;
	logic [32:0] div_den;
	assign div_sh = {drem_q[31:0], dnum_q[15]};
	assign div_den = {1'b0, root_q};

	logic [31:0] half_len;
	assign half_len = {1'b0, root_q[31:1]};

	logic [1:0] sel;
	assign sel = step_q;

	always_comb begin
		state_d = state_q;
		rd_addr = idx_a;
		wr_addr = idx_a;
		coord_we = 1'b0;
		acc_we = 1'b0;
		coord_wd = {item_q.coord_x, item_q.coord_y, item_q.coord_z};
		acc_wd = '0;
		case (state_q)
			mvna_pkg::ST_IDLE: begin
				if (in_fire) begin
					case (in_ch.data.action)
						mvna_pkg::ACT_LOAD: state_d = mvna_pkg::ST_ACC_WR;
						mvna_pkg::ACT_TRI: state_d = mvna_pkg::ST_RD_A;
						mvna_pkg::ACT_READ: state_d = mvna_pkg::ST_RSUM_W;
						default: state_d = mvna_pkg::ST_OUT;
					endcase
				end
			end
			mvna_pkg::ST_RD_A: begin
				rd_addr = idx_a;
				state_d = mvna_pkg::ST_RD_B;
			end
			mvna_pkg::ST_RD_B: begin
				rd_addr = idx_b;
				state_d = mvna_pkg::ST_RD_C;
			end
			mvna_pkg::ST_RD_C: begin
				rd_addr = idx_c;
				state_d = mvna_pkg::ST_RD_W;
			end
			mvna_pkg::ST_RD_W: state_d = mvna_pkg::ST_CROSS1;
			mvna_pkg::ST_CROSS1: state_d = mvna_pkg::ST_CROSS2;
			mvna_pkg::ST_CROSS2: begin
				if (step_q == 2'd2) state_d = mvna_pkg::ST_CROSS3;
			end
			mvna_pkg::ST_CROSS3: state_d = mvna_pkg::ST_SHIFT;
			mvna_pkg::ST_RSUM_W: begin
				rd_addr = idx_a;
				state_d = mvna_pkg::ST_RSUM;
			end
			mvna_pkg::ST_RSUM: state_d = mvna_pkg::ST_SHIFT;
			mvna_pkg::ST_SHIFT: begin
				if (a_max < 41'(1 << 30)) state_d = mvna_pkg::ST_SQ;
			end
			mvna_pkg::ST_SQ: begin
				if (step_q == 2'd2) state_d = mvna_pkg::ST_SQRT;
			end
			mvna_pkg::ST_SQRT: begin
				if (cnt_q == 6'd31) state_d = mvna_pkg::ST_DIV;
			end
			mvna_pkg::ST_DIV: begin
				if (root_q == '0) begin
					state_d = (item_q.action == mvna_pkg::ACT_TRI) ?
						mvna_pkg::ST_ACC_RD : mvna_pkg::ST_OUT;
				end else if (cnt_q == 6'd49 && step_q == 2'd2) begin
					state_d = (item_q.action == mvna_pkg::ACT_TRI) ?
						mvna_pkg::ST_ACC_RD : mvna_pkg::ST_OUT;
				end
			end
			mvna_pkg::ST_ACC_RD: begin
				rd_addr = corner_idx;
				state_d = mvna_pkg::ST_ACC_W;
			end
			mvna_pkg::ST_ACC_W: begin
				wr_addr = corner_idx;
				acc_we = 1'b1;
				acc_wd = {sat_add(acc_rd_q[3*SW+7:2*SW+8], n_q[0]),
					sat_add(acc_rd_q[2*SW+7:SW+8], n_q[1]),
					sat_add(acc_rd_q[SW+7:8], n_q[2]),
					(acc_cnt == 8'd255) ? acc_cnt : acc_cnt + 8'd1};
				state_d = (corner_q == 2'd2) ? mvna_pkg::ST_OUT : mvna_pkg::ST_ACC_RD;
			end
			mvna_pkg::ST_ACC_WR: begin
				wr_addr = idx_a;
				coord_we = 1'b1;
				acc_we = 1'b1;
				acc_wd = '0;
				state_d = mvna_pkg::ST_OUT;
			end
			mvna_pkg::ST_OUT: state_d = mvna_pkg::ST_IDLE;
			default: state_d = mvna_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mvna_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mvna_pkg::ST_OUT) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	logic [46:0] a_sel;
	assign a_sel = {2'b00, a_q[sel][29:0], 15'd0} + {15'd0, half_len};

	always_ff @(posedge clk) begin
		case (state_q)
			mvna_pkg::ST_IDLE: begin
				if (in_fire) item_q <= in_ch.data;
				step_q <= '0;
				corner_q <= '0;
				count_q <= '0;
				status_q <= 1'b0;
				for (int i = 0; i < 3; i++) n_q[i] <= '0;
			end
			mvna_pkg::ST_RD_B: va_q <= rd_co;
			mvna_pkg::ST_RD_C: begin
				for (int i = 0; i < 3; i++) e1_q[i] <= rd_co[i] - va_q[i];
			end
			mvna_pkg::ST_RD_W: begin
				for (int i = 0; i < 3; i++) e2_q[i] <= rd_co[i] - va_q[i];
			end
			mvna_pkg::ST_CROSS1: step_q <= '0;
			mvna_pkg::ST_CROSS2: begin
				case (step_q)
					2'd0: begin
						prod_q <= prod_a;
						c_q[0] <= 41'(prod_b);
					end
					2'd1: begin
						c_q[0] <= 41'(prod_q) - c_q[0];
						prod_q <= prod_a;
						c_q[1] <= 41'(prod_b);
					end
					default: begin
						c_q[1] <= 41'(prod_q) - c_q[1];
						prod_q <= prod_a;
						c_q[2] <= 41'(prod_b);
					end
				endcase
				step_q <= step_q + 2'd1;
			end
			mvna_pkg::ST_CROSS3: begin
				for (int i = 0; i < 3; i++) begin
					logic signed [40:0] v;
					v = (i == 2) ? 41'(prod_q) - c_q[2] : c_q[i];
					neg_q[i] <= v[40];
					a_q[i] <= v[40] ? 41'(-v) : v;
				end
			end
			mvna_pkg::ST_RSUM: begin
				logic signed [40:0] v;
				for (int i = 0; i < 3; i++) begin
					v = 41'($signed(acc_rd_q[(3-i)*SW+7 -: SW]));
					neg_q[i] <= v[40];
					a_q[i] <= v[40] ? 41'(-v) : v;
				end
				count_q <= acc_rd_q[7:0];
			end
			mvna_pkg::ST_SHIFT: begin
				if (!(a_max < 41'(1 << 30)))
					for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 1;
				step_q <= '0;
				sq_q <= '0;
			end
			mvna_pkg::ST_SQ: begin
				sq_q <= sq_q + 64'(a_q[sel][29:0]) * 64'(a_q[sel][29:0]);
				step_q <= step_q + 2'd1;
				cnt_q <= '0;
				rem_q <= '0;
				root_q <= '0;
			end
			mvna_pkg::ST_SQRT: begin
				if (sqrt_rem_sh >= sqrt_trial) begin
					rem_q <= sqrt_rem_sh - sqrt_trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q <= sqrt_rem_sh;
					root_q <= {root_q[30:0], 1'b0};
				end
				sq_q <= {sq_q[61:0], 2'b00};
				cnt_q <= cnt_q + 6'd1;
				step_q <= '0;
			end
			mvna_pkg::ST_DIV: begin
				logic [15:0] qc;
				qc = quo_q[15] ? 16'(mvna_pkg::Q15_MAX) : quo_q;
				if (root_q == '0) begin
					status_q <= 1'b1;
					for (int i = 0; i < 3; i++) n_q[i] <= '0;
				end else if (cnt_q == 6'd32) begin
					dnum_q <= a_sel[15:0];
					drem_q <= {2'b00, a_sel[46:16]};
					quo_q <= '0;
					cnt_q <= 6'd33;
				end else if (cnt_q == 6'd49) begin
					n_q[sel] <= neg_q[sel] ? -$signed(qc) : $signed(qc);
					step_q <= step_q + 2'd1;
					cnt_q <= 6'd32;
				end else begin
					if (div_sh >= div_den) begin
						drem_q <= div_sh - div_den;
						quo_q <= {quo_q[14:0], 1'b1};
					end else begin
						drem_q <= div_sh;
						quo_q <= {quo_q[14:0], 1'b0};
					end
					dnum_q <= {dnum_q[14:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
				end
			end
			mvna_pkg::ST_ACC_W: corner_q <= corner_q + 2'd1;
			mvna_pkg::ST_OUT: begin
				out_q.normal_x <= n_q[0];
				out_q.normal_y <= n_q[1];
				out_q.normal_z <= n_q[2];
				out_q.face_count <= (item_q.action == mvna_pkg::ACT_READ) ? count_q : '0;
				out_q.status <= status_q;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/mvna_checker.sv =====
module mvna_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_status,
	input logic signed [15:0] out_nx
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status |-> out_nx == 16'sd0)
		else $error("degenerate result with nonzero normal");

endmodule

bind mesh_vertex_normal_accumulator mvna_checker u_mvna_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_status(out_ch.data.status),
	.out_nx(out_ch.data.normal_x)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 200;

	logic clk;
	logic arst_n;

	mvna_in_if in_ch();
	mvna_out_if out_ch();

	mesh_vertex_normal_accumulator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	logic signed [15:0] vert_x[mvna_pkg::VERTEX_SLOTS];
	logic signed [15:0] vert_y[mvna_pkg::VERTEX_SLOTS];
	logic signed [15:0] vert_z[mvna_pkg::VERTEX_SLOTS];
	int sum_x[mvna_pkg::VERTEX_SLOTS];
	int sum_y[mvna_pkg::VERTEX_SLOTS];
	int sum_z[mvna_pkg::VERTEX_SLOTS];
	int unsigned face_cnt[mvna_pkg::VERTEX_SLOTS];
	bit loaded[mvna_pkg::VERTEX_SLOTS];
	int loaded_list[$];

	mvna_pkg::out_item_t normal_queue[$];
	int mismatch_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int tri_seen = 0;
	int degenerate_seen = 0;
	int idle_cycles = 0;
	bit idle_enable = 1'b1;
	int hold_request = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic mvna_pkg::out_item_t unit_normal(longint cx, longint cy, longint cz);
		longint cc[3];
		longint unsigned a[3];
		longint unsigned m;
		longint unsigned sq;
		longint unsigned len;
		longint unsigned q;
		bit neg[3];
		int n[3];
		mvna_pkg::out_item_t r;
		cc[0] = cx;
		cc[1] = cy;
		cc[2] = cz;
		m = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = cc[i] < 0;
			a[i] = neg[i] ? -cc[i] : cc[i];
			if (a[i] > m) m = a[i];
		end
		while (m >= (64'd1 << 30)) begin
			m >>= 1;
			for (int i = 0; i < 3; i++) a[i] >>= 1;
		end
		sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		len = floor_sqrt(sq);
		r = '0;
		if (len == 0) begin
			r.status = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			q = (a[i] * 32768 + (len >> 1)) / len;
			if (q > mvna_pkg::Q15_MAX) q = mvna_pkg::Q15_MAX;
			n[i] = neg[i] ? -int'(q) : int'(q);
		end
		r.normal_x = 16'(n[0]);
		r.normal_y = 16'(n[1]);
		r.normal_z = 16'(n[2]);
		return r;
	endfunction

	function automatic int sat_sum(int s, int d);
		int r;
		r = s + d;
		if (r > 8388607) r = 8388607;
		if (r < -8388608) r = -8388608;
		return r;
	endfunction

	function automatic void add_face(int v, mvna_pkg::out_item_t f);
		sum_x[v] = sat_sum(sum_x[v], f.normal_x);
		sum_y[v] = sat_sum(sum_y[v], f.normal_y);
		sum_z[v] = sat_sum(sum_z[v], f.normal_z);
		if (face_cnt[v] < 255) face_cnt[v]++;
	endfunction

	function automatic mvna_pkg::out_item_t predict_normal(mvna_pkg::in_item_t it);
		mvna_pkg::out_item_t r;
		int va;
		int vb;
		int vc;
		longint e1[3];
		longint e2[3];
		va = it.index_a;
		vb = it.index_b;
		vc = it.index_c;
		r = '0;
		case (mvna_pkg::action_t'(it.action))
			mvna_pkg::ACT_LOAD: begin
				vert_x[va] = it.coord_x;
				vert_y[va] = it.coord_y;
				vert_z[va] = it.coord_z;
				sum_x[va] = 0;
				sum_y[va] = 0;
				sum_z[va] = 0;
				face_cnt[va] = 0;
			end
			mvna_pkg::ACT_TRI: begin
				e1[0] = longint'(vert_x[vb]) - vert_x[va];
				e1[1] = longint'(vert_y[vb]) - vert_y[va];
				e1[2] = longint'(vert_z[vb]) - vert_z[va];
				e2[0] = longint'(vert_x[vc]) - vert_x[va];
				e2[1] = longint'(vert_y[vc]) - vert_y[va];
				e2[2] = longint'(vert_z[vc]) - vert_z[va];
				r = unit_normal(e1[1] * e2[2] - e1[2] * e2[1],
					e1[2] * e2[0] - e1[0] * e2[2],
					e1[0] * e2[1] - e1[1] * e2[0]);
				add_face(va, r);
				add_face(vb, r);
				add_face(vc, r);
			end
			mvna_pkg::ACT_READ: begin
				r = unit_normal(sum_x[va], sum_y[va], sum_z[va]);
				r.face_count = 8'(face_cnt[va]);
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		mvna_pkg::out_item_t got;
		mvna_pkg::out_item_t want;
		if (in_ch.valid && in_ch.ready) normal_queue.push_back(predict_normal(in_ch.data));
		if (out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			results_seen++;
			if (normal_queue.size() == 0) begin
				report("unexpected transaction", 0, 0);
			end else begin
				want = normal_queue.pop_front();
				if (got.normal_x !== want.normal_x) report("normal_x", got.normal_x, want.normal_x);
				if (got.normal_y !== want.normal_y) report("normal_y", got.normal_y, want.normal_y);
				if (got.normal_z !== want.normal_z) report("normal_z", got.normal_z, want.normal_z);
				if (got.face_count !== want.face_count)
					report("face_count", got.face_count, want.face_count);
				if (got.status !== want.status) report("status", got.status, want.status);
				if (want.status) degenerate_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles = 0;
		end else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired at %0t", $time);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int hold;
		bit hold_taken;
		hold = 0;
		hold_taken = 1'b0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0 && !hold_taken) begin
				hold = hold_request;
				hold_taken = 1'b1;
			end
			if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= idle_enable ? ($urandom_range(99) >= 9) : 1'b1;
			end
		end
	end

	task automatic send_item(mvna_pkg::in_item_t it);
		if (idle_enable && $urandom_range(99) < 9) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		items_sent++;
		if (it.action == mvna_pkg::ACT_LOAD && !loaded[it.index_a]) begin
			loaded[it.index_a] = 1'b1;
			loaded_list.push_back(it.index_a);
		end
	endtask

	task automatic send_op(mvna_pkg::action_t act, int a, int b, int c,
			int x = 0, int y = 0, int z = 0);
		mvna_pkg::in_item_t it;
		it.action = act;
		it.index_a = 12'(a);
		it.index_b = 12'(b);
		it.index_c = 12'(c);
		it.coord_x = 16'(x);
		it.coord_y = 16'(y);
		it.coord_z = 16'(z);
		if (act == mvna_pkg::ACT_TRI) tri_seen++;
		send_item(it);
	endtask

	task automatic test_directed();
		send_op(mvna_pkg::ACT_LOAD, 0, 0, 0, 0, 0, 0);
		send_op(mvna_pkg::ACT_LOAD, 4095, 0, 0, -32768, -32768, -32768);
		send_op(mvna_pkg::ACT_LOAD, 1, 0, 0, 32767, -32768, 0);
		send_op(mvna_pkg::ACT_LOAD, 2, 0, 0, -32768, 32767, 32767);
		send_op(mvna_pkg::ACT_LOAD, 3, 0, 0, 100, 0, 0);
		send_op(mvna_pkg::ACT_LOAD, 4, 0, 0, 0, 100, 0);
		send_op(mvna_pkg::ACT_TRI, 0, 3, 4, 21845, 10922, -1);
		send_op(mvna_pkg::ACT_TRI, 4095, 1, 2);
		send_op(mvna_pkg::ACT_TRI, 0, 0, 3);
		send_op(mvna_pkg::ACT_TRI, 0, 4, 3);
		send_op(mvna_pkg::ACT_TRI, 3, 3, 3);
		send_op(mvna_pkg::ACT_READ, 0, 4095, 4095);
		send_op(mvna_pkg::ACT_READ, 3, 0, 0);
		send_op(mvna_pkg::ACT_READ, 4095, 0, 0);
		send_op(mvna_pkg::ACT_READ, 1, 0, 0);
		send_op(mvna_pkg::ACT_LOAD, 5, 0, 0, 7, 7, 7);
		send_op(mvna_pkg::ACT_READ, 5, 0, 0);
		send_op(mvna_pkg::ACT_NONE, 4095, 4095, 4095, -1, -1, -1);
		send_op(mvna_pkg::ACT_NONE, 0, 0, 0, 0, 0, 0);
		send_op(mvna_pkg::ACT_READ, 2, 0, 0);
	endtask

	task automatic test_saturation();
		send_op(mvna_pkg::ACT_LOAD, 10, 0, 0, 0, 0, 0);
		send_op(mvna_pkg::ACT_LOAD, 11, 0, 0, 50, 0, 0);
		send_op(mvna_pkg::ACT_LOAD, 12, 0, 0, 0, 50, 0);
		for (int i = 0; i < 262; i++) send_op(mvna_pkg::ACT_TRI, 10, 11, 12);
		send_op(mvna_pkg::ACT_READ, 10, 0, 0);
		for (int i = 0; i < 262; i++) send_op(mvna_pkg::ACT_TRI, 11, 10, 11);
		send_op(mvna_pkg::ACT_READ, 11, 0, 0);
		send_op(mvna_pkg::ACT_READ, 12, 0, 0);
	endtask

	task automatic test_backpressure();
		@(negedge clk);
		hold_request = 400;
		for (int i = 0; i < 20; i++) begin
			send_op(mvna_pkg::ACT_TRI, 0, 3, 4);
			send_op(mvna_pkg::ACT_READ, 0, 0, 0);
		end
	endtask

	function automatic int any_loaded();
		return loaded_list[$urandom_range(loaded_list.size() - 1)];
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(9))
			0: return -32768;
			1: return 32767;
			2: return int'($urandom_range(128)) - 64;
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	task automatic test_random(int count);
		int pick;
		int idx;
		for (int i = 0; i < count; i++) begin
			if (i == count / 3) idle_enable = 1'b0;
			if (i == count / 2) idle_enable = 1'b1;
			pick = $urandom_range(99);
			if (pick < 15) begin
				idx = ($urandom_range(1)) ? $urandom_range(63) : $urandom_range(4095);
				send_op(mvna_pkg::ACT_LOAD, idx, $urandom_range(4095), $urandom_range(4095),
					rand_coord(), rand_coord(), rand_coord());
			end else if (pick < 70) begin
				send_op(mvna_pkg::ACT_TRI, any_loaded(), any_loaded(), any_loaded(),
					rand_coord(), rand_coord(), rand_coord());
			end else if (pick < 95) begin
				send_op(mvna_pkg::ACT_READ, any_loaded(), $urandom_range(4095),
					$urandom_range(4095), rand_coord(), rand_coord(), rand_coord());
			end else begin
				send_op(mvna_pkg::ACT_NONE, $urandom_range(4095), $urandom_range(4095),
					$urandom_range(4095), rand_coord(), rand_coord(), rand_coord());
			end
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_saturation();
		test_backpressure();
		test_random(1100);
		in_ch.valid <= 1'b0;
		while (normal_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d transactions (%0d triangles), checked %0d results", items_sent,
			tri_seen, results_seen);
		$display("Degenerate normals %0d, vertices loaded %0d, with saturation and long stall",
			degenerate_seen, loaded_list.size());
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/mvna_pkg.sv
rtl/core/mvna_in_if.sv
rtl/core/mvna_out_if.sv
rtl/core/mesh_vertex_normal_accumulator.sv
rtl/core/mvna_checker.sv
sim/tb_top.sv
